[hdl/its_pkg.sv]
// ----------------------------------------------------------------------------
// its_pkg
// Shared constants and types for the interval timer stack: stack geometry,
// register indexes, error codes, flag positions and the interfaces between
// the sequencer, the divider and the mark memory.
// ----------------------------------------------------------------------------
package its_pkg;

    localparam int STACK_DEPTH = 10;
    localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam int DATA_W      = 32;
    localparam int TICKS_W     = 23;
    localparam int ERR_W       = 2;
    localparam int FLAGS_W     = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 72;

    localparam logic [DATA_W-1:0]  SCALE_DIVISOR     = 32'd1000;
    localparam logic [TICKS_W-1:0] TICKS_RESET       = 23'd1193;
    localparam logic [DATA_W-1:0]  WRAP_RESET        = 32'd3600140;

    // The product with SCALE_RECIP shifted right by SCALE_SHIFT equals the
    // quotient by SCALE_DIVISOR for every 32-bit dividend.
    localparam logic [DATA_W-1:0]  SCALE_RECIP       = 32'd274877907;
    localparam int                 SCALE_SHIFT       = 38;

    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_MS      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_INCREMENT_MS = 1'b1;

    localparam logic OP_CLOCK = 1'b0;
    localparam logic OP_STACK = 1'b1;

    localparam int FLAG_PUSH = 0;
    localparam int FLAG_POP  = 1;
    localparam int FLAG_READ = 2;
    localparam int FLAG_SET  = 3;

    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY    = 2'd2;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [DATA_W-1:0] wr_data;
    } mark_req_t;

endpackage

[hdl/interval_timer_stack_core.sv]
// ----------------------------------------------------------------------------
// interval_timer_stack_core
// Millisecond clock built from samples of a free-running tick counter, with
// a stack of saved marks for measuring elapsed intervals.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_        in         tuser: opcode; tdata: counter_sample, mode_flags,
//                      result_scale
// m_        out        tdata: elapsed, now_ms, error_code
// cfg_      in         write enable, register index, write data
//
// A clock read passes through a decode state, the 32-step restoring divider
// for the tick conversion and a completion state. A stack read or set adds
// an elapsed state, and a scaled read adds a multiply state and a scale
// state, the divide by 1000 being a reciprocal multiplication. An error or
// a plain push or pop goes from the decode state straight to completion.
// After reset the stack is empty and every mark reads zero until written.
// A new transaction is accepted from the cycle after a result is loaded, even
// while that result waits; a finished result is held until the output
// register is free.
// ----------------------------------------------------------------------------
module interval_timer_stack_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // opcode
    input  logic                             s_tuser,
    // counter_sample, mode_flags, result_scale, zero fill
    input  logic [its_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // elapsed, now_ms, error_code, zero fill
    output logic [its_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             cfg_we,
    input  logic [its_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [its_pkg::DATA_W-1:0]       cfg_data
);
    import its_pkg::*;

    localparam logic [2:0] ST_IDLE        = 3'd0;
    localparam logic [2:0] ST_DECODE      = 3'd1;
    localparam logic [2:0] ST_CLK_DIV     = 3'd2;
    localparam logic [2:0] ST_ELAPSED     = 3'd3;
    localparam logic [2:0] ST_MUL         = 3'd4;
    localparam logic [2:0] ST_SCALE       = 3'd5;
    localparam logic [2:0] ST_DONE        = 3'd7;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;

    logic [TICKS_W-1:0] ticks_reg;
    logic [DATA_W-1:0]  wrap_reg;
    logic [DATA_W-1:0]  last_reg;
    logic [DATA_W-1:0]  base_reg;
    logic [LVL_W-1:0]   level_reg;

    logic               opcode_reg;
    logic [DATA_W-1:0]  sample_reg;
    logic [FLAGS_W-1:0] flags_reg;
    logic [DATA_W-1:0]  scale_reg;
    logic [IDX_W-1:0]   top_reg;

    logic [DATA_W-1:0]  elapsed_reg;
    logic [DATA_W-1:0]  now_reg;
    logic [ERR_W-1:0]   err_reg;

    logic               m_valid_reg;
    logic [DATA_W-1:0]  out_elapsed_reg;
    logic [DATA_W-1:0]  out_now_reg;
    logic [ERR_W-1:0]   out_err_reg;

    logic [ERR_W-1:0]   err;
    logic [LVL_W-1:0]   top_level;
    logic               needs_clock;
    logic               clock_start;
    logic               out_load;
    logic [DATA_W-1:0]  now_calc;
    logic [DATA_W-1:0]  prod_lo;
    logic [2*DATA_W-1:0] recip_prod;
    logic [DATA_W-1:0]  mark_rd;

    div_req_t           div_req;
    div_rsp_t           div_rsp;
    mark_req_t          mark_req;

    always_comb begin
        err = ERR_NONE;
        if (opcode_reg == OP_STACK) begin
            if (flags_reg[FLAG_PUSH]) begin
                if (level_reg >= LVL_W'(STACK_DEPTH)) begin
                    err = ERR_OVERFLOW;
                end
            end else if (level_reg == '0) begin
                err = ERR_EMPTY;
            end
        end
    end

    assign top_level   = flags_reg[FLAG_PUSH] ? level_reg : level_reg - 1'b1;
    assign needs_clock = (opcode_reg == OP_CLOCK) ||
                         ((err == ERR_NONE) && (flags_reg[FLAG_READ] || flags_reg[FLAG_SET]));
    assign clock_start = (state_reg == ST_DECODE) && needs_clock;
    assign now_calc    = base_reg + div_rsp.quotient;
    assign prod_lo     = elapsed_reg * scale_reg;
    assign recip_prod  = (2*DATA_W)'(elapsed_reg) * (2*DATA_W)'(SCALE_RECIP);
    assign out_load    = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    assign div_req.start    = clock_start;
    assign div_req.dividend = sample_reg;
    assign div_req.divisor  = {{(DATA_W-TICKS_W){1'b0}}, ticks_reg};

    assign mark_req.rd_en   = (state_reg == ST_DECODE) && (opcode_reg == OP_STACK) &&
                              (err == ERR_NONE);
    assign mark_req.rd_addr = top_level[IDX_W-1:0];
    assign mark_req.wr_en   = (state_reg == ST_CLK_DIV) && div_rsp.done &&
                              (opcode_reg == OP_STACK) && flags_reg[FLAG_SET];
    assign mark_req.wr_addr = top_reg;
    assign mark_req.wr_data = now_calc;

    its_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    its_mark_ram u_mark_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mark_req),
        .rd_data (mark_rd)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = needs_clock ? ST_CLK_DIV : ST_DONE;
            end
            ST_CLK_DIV: begin
                if (div_rsp.done) begin
                    state_next = (opcode_reg == OP_CLOCK) ? ST_DONE : ST_ELAPSED;
                end
            end
            ST_ELAPSED: begin
                if (flags_reg[FLAG_READ] && (scale_reg != '0)) begin
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL: begin
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ticks_reg   <= TICKS_RESET;
            wrap_reg    <= WRAP_RESET;
            last_reg    <= '0;
            base_reg    <= '0;
            level_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_TICKS_PER_MS:      ticks_reg <= cfg_data[TICKS_W-1:0];
                    REG_WRAP_INCREMENT_MS: wrap_reg  <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (clock_start) begin
                last_reg <= sample_reg;
                if (last_reg > sample_reg) begin
                    base_reg <= base_reg + wrap_reg;
                end
            end
            if ((state_reg == ST_DECODE) && (opcode_reg == OP_STACK) && (err == ERR_NONE)) begin
                level_reg <= level_reg + LVL_W'(flags_reg[FLAG_PUSH])
                                       - LVL_W'(flags_reg[FLAG_POP]);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    opcode_reg <= s_tuser;
                    sample_reg <= s_tdata[31:0];
                    flags_reg  <= s_tdata[35:32];
                    scale_reg  <= s_tdata[67:36];
                end
            end
            ST_DECODE: begin
                elapsed_reg <= '0;
                now_reg     <= '0;
                err_reg     <= err;
                top_reg     <= top_level[IDX_W-1:0];
            end
            ST_CLK_DIV: begin
                if (div_rsp.done) begin
                    now_reg <= now_calc;
                end
            end
            ST_ELAPSED: begin
                if (flags_reg[FLAG_READ]) begin
                    elapsed_reg <= now_reg - mark_rd;
                end
            end
            ST_MUL: begin
                elapsed_reg <= prod_lo;
            end
            ST_SCALE: begin
                elapsed_reg <= DATA_W'(recip_prod >> SCALE_SHIFT);
            end
            default: begin
            end
        endcase
        if (out_load) begin
            out_elapsed_reg <= elapsed_reg;
            out_now_reg     <= now_reg;
            out_err_reg     <= err_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-2*DATA_W-ERR_W){1'b0}}, out_err_reg, out_now_reg,
                       out_elapsed_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LVL_W'(STACK_DEPTH))
        else $error("stack level beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.busy |-> (state_reg == ST_CLK_DIV))
        else $error("divider busy outside the divide state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside completion");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (out_err_reg != ERR_NONE)) |->
        (out_elapsed_reg == '0) && (out_now_reg == '0))
        else $error("error result carries time values");

endmodule

[hdl/its_divider.sv]
// ----------------------------------------------------------------------------
// its_divider
// Restoring unsigned divider, one quotient bit per cycle. A zero divisor
// yields a quotient of all ones.
// ----------------------------------------------------------------------------
module its_divider (
    input  logic             aclk,
    input  logic             aresetn,
    input  its_pkg::div_req_t req,
    output its_pkg::div_rsp_t rsp
);
    import its_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] div_reg;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              fits;

    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign fits    = !diff[DATA_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else if (req.start) begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else if (busy_reg) begin
            count_reg <= count_reg + 1'b1;
            if (count_reg == CNT_W'(DATA_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            div_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            quo_reg <= {quo_reg[DATA_W-2:0], fits};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[hdl/its_mark_ram.sv]
// ----------------------------------------------------------------------------
// its_mark_ram
// Storage for the stack of millisecond marks: one write and one registered
// read per cycle. Entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module its_mark_ram (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  its_pkg::mark_req_t        req,
    output logic [its_pkg::DATA_W-1:0] rd_data
);
    import its_pkg::*;

    logic [DATA_W-1:0]      mem [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] valid_reg;
    logic [DATA_W-1:0]      rd_q_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_q_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule
